/* src/pidff_pkg.sv */
// Shared types and constants of the PID controller with feedforward.
package pidff_pkg;

  // Q16.16 signal width and Q8.24 gain width
  localparam int unsigned SigW = 32;
  localparam int unsigned GainW = 32;
  // magnitude of a difference of two signals
  localparam int unsigned MagW = SigW + 1;
  // truncated product, signed, with margin
  localparam int unsigned ProdW = 43;
  // fractional bits of a gain
  localparam int unsigned GainFrac = 24;

  // register indexes on the configuration port
  localparam logic [2:0] REG_GAIN_P  = 3'd0;
  localparam logic [2:0] REG_GAIN_I  = 3'd1;
  localparam logic [2:0] REG_GAIN_D  = 3'd2;
  localparam logic [2:0] REG_FF_GAIN = 3'd3;
  localparam logic [2:0] REG_OUT_MIN = 3'd4;
  localparam logic [2:0] REG_OUT_MAX = 3'd5;
  localparam logic [2:0] REG_REVERSE = 3'd6;
  localparam logic [2:0] REG_AUTO    = 3'd7;

  // reset value of the upper drive limit (1.0 in Q16.16)
  localparam logic signed [SigW-1:0] OutMaxReset = 32'sd65536;

  typedef struct packed {
    logic signed [SigW-1:0] setpoint;
    logic signed [SigW-1:0] measurement;
    logic signed [SigW-1:0] ff_reference;
    logic                   ff_enable;
  } in_word_t;

  typedef struct packed {
    logic signed [SigW-1:0] drive;
    logic                   computed;
  } out_word_t;

  typedef struct packed {
    logic [GainW-1:0]       gain_p;
    logic [GainW-1:0]       gain_i;
    logic [GainW-1:0]       gain_d;
    logic [GainW-1:0]       ff_gain;
    logic signed [SigW-1:0] out_min;
    logic signed [SigW-1:0] out_max;
    logic                   reverse;
    logic                   automatic_cfg;
  } cfg_t;

  // products handed from the multiply stage to the state update
  typedef struct packed {
    logic signed [ProdW-1:0] p_term;
    logic signed [ProdW-1:0] i_term;
    logic signed [ProdW-1:0] d_term;
    logic signed [ProdW-1:0] f_term;
    logic                    ff_enable;
  } prod_t;

endpackage

/* src/pid_controller_with_feedforward_unit.sv */
// Top level of the PID controller with derivative on measurement and feedforward.
//
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+------------------------------
//  input    | in        | in_valid_i / in_ready_o   | in_word_t (sp, meas, ref, en)
//  result   | out       | out_valid_o / out_ready_i | out_word_t (drive, computed)
//  config   | in        | psel/penable/pready (APB) | 32-bit registers at 4*i
//
// One word per cycle while results are taken; a word passes the input register, the
// multiply stage with four 33x32 multipliers, and the state update and result
// register.
// The integrator and drive loop closes within the update stage.
// Reset clears the valid bits, held values, configuration and state; there is no clearing pass.
// A stalled result holds the pipe back stage by stage; bubbles are filled first.
module pid_controller_with_feedforward_unit
  import pidff_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic load1, load2, load3;

  logic signed [SigW-1:0] held_meas_q, prev_ref_q;

  logic [MagW-1:0] err_mag_q, din_mag_q, ffd_mag_q;
  logic            err_neg_q, din_neg_q, ffd_neg_q, ff_en1_q;

  logic signed [MagW-1:0] err_d, din_d, ffd_d;

  prod_t prod_d, prod_q;

  function automatic logic [MagW-1:0] mag_of(input logic signed [MagW-1:0] v);
    return v[MagW-1] ? MagW'(-v) : MagW'(v);
  endfunction

  pidff_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stage flow control
  assign rdy3  = !v3_q || out_ready_i;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign load1 = in_valid_i && rdy1;
  assign load2 = v1_q && rdy2;
  assign load3 = v2_q && rdy3;

  assign in_ready_o  = rdy1;
  assign out_valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // error of the word, and differences against the previous word's measurement and reference
  assign err_d = {in_data_i.setpoint[SigW-1], in_data_i.setpoint}
               - {in_data_i.measurement[SigW-1], in_data_i.measurement};
  assign din_d = {in_data_i.measurement[SigW-1], in_data_i.measurement}
               - {held_meas_q[SigW-1], held_meas_q};
  assign ffd_d = {in_data_i.ff_reference[SigW-1], in_data_i.ff_reference}
               - {prev_ref_q[SigW-1], prev_ref_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_meas_q <= '0;
      prev_ref_q  <= '0;
    end else if (load1) begin
      held_meas_q <= in_data_i.measurement;
      prev_ref_q  <= in_data_i.ff_reference;
    end
  end

  // input register, in sign-magnitude form
  always_ff @(posedge clk_i) begin
    if (load1) begin
      err_mag_q <= mag_of(err_d);
      err_neg_q <= err_d[MagW-1];
      din_mag_q <= mag_of(din_d);
      din_neg_q <= din_d[MagW-1];
      ffd_mag_q <= mag_of(ffd_d);
      ffd_neg_q <= ffd_d[MagW-1];
      ff_en1_q  <= in_data_i.ff_enable;
    end
  end

  // multiply stage
  pidff_mulq u_mul_p (
    .mag_i (err_mag_q), .neg_i (err_neg_q), .gain_i (cfg.gain_p),
    .inv_i (cfg.reverse), .prod_o (prod_d.p_term)
  );
  pidff_mulq u_mul_i (
    .mag_i (err_mag_q), .neg_i (err_neg_q), .gain_i (cfg.gain_i),
    .inv_i (cfg.reverse), .prod_o (prod_d.i_term)
  );
  pidff_mulq u_mul_d (
    .mag_i (din_mag_q), .neg_i (din_neg_q), .gain_i (cfg.gain_d),
    .inv_i (cfg.reverse), .prod_o (prod_d.d_term)
  );
  pidff_mulq u_mul_f (
    .mag_i (ffd_mag_q), .neg_i (ffd_neg_q), .gain_i (cfg.ff_gain),
    .inv_i (1'b0), .prod_o (prod_d.f_term)
  );
  assign prod_d.ff_enable = ff_en1_q;

  always_ff @(posedge clk_i) begin
    if (load2) prod_q <= prod_d;
  end

  // state update and result register
  pidff_update u_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load3),
    .prod_i   (prod_q),
    .cfg_i    (cfg),
    .result_o (out_data_o)
  );

  // a freshly clamped result respects ordered limits; a plain manual hold is not clamped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load3 && (cfg.automatic_cfg || prod_q.ff_enable) && (cfg.out_min <= cfg.out_max) |=>
      (out_data_o.drive >= $past(cfg.out_min)) &&
      (out_data_o.drive <= $past(cfg.out_max)))
    else $error("drive outside limits");

  // a fresh result is shown and carries the mode it was computed in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load3 |=> out_valid_o && (out_data_o.computed == $past(cfg.automatic_cfg)))
    else $error("result lost or wrong mode flag");

  // a held product word is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !rdy3 |=> v2_q && v3_q)
    else $error("product stage dropped a word");

endmodule

/* src/pidff_cfg.sv */
// Configuration register file with an APB-style write and read port.
module pidff_cfg
  import pidff_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p        <= '0;
      cfg_q.gain_i        <= '0;
      cfg_q.gain_d        <= '0;
      cfg_q.ff_gain       <= '0;
      cfg_q.out_min       <= '0;
      cfg_q.out_max       <= OutMaxReset;
      cfg_q.reverse       <= 1'b0;
      cfg_q.automatic_cfg <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN_P:  cfg_q.gain_p        <= pwdata;
        REG_GAIN_I:  cfg_q.gain_i        <= pwdata;
        REG_GAIN_D:  cfg_q.gain_d        <= pwdata;
        REG_FF_GAIN: cfg_q.ff_gain       <= pwdata;
        REG_OUT_MIN: cfg_q.out_min       <= pwdata;
        REG_OUT_MAX: cfg_q.out_max       <= pwdata;
        REG_REVERSE: cfg_q.reverse       <= pwdata[0];
        REG_AUTO:    cfg_q.automatic_cfg <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    case (idx)
      REG_GAIN_P:  prdata = cfg_q.gain_p;
      REG_GAIN_I:  prdata = cfg_q.gain_i;
      REG_GAIN_D:  prdata = cfg_q.gain_d;
      REG_FF_GAIN: prdata = cfg_q.ff_gain;
      REG_OUT_MIN: prdata = cfg_q.out_min;
      REG_OUT_MAX: prdata = cfg_q.out_max;
      REG_REVERSE: prdata = {31'd0, cfg_q.reverse};
      REG_AUTO:    prdata = {31'd0, cfg_q.automatic_cfg};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* src/pidff_mulq.sv */
// Sign-magnitude times Q8.24 gain, truncated toward zero, optional negation.
module pidff_mulq
  import pidff_pkg::*;
(
  input  logic [MagW-1:0]         mag_i,
  input  logic                    neg_i,
  input  logic [GainW-1:0]        gain_i,
  input  logic                    inv_i,
  output logic signed [ProdW-1:0] prod_o
);

  localparam int unsigned FullW = MagW + GainW;
  localparam int unsigned ShW = FullW - GainFrac;

  logic [FullW-1:0]       full;
  logic [ShW-1:0]         shifted;
  logic signed [ProdW-1:0] ext;

  // truncating the magnitude rounds toward zero
  assign full    = FullW'(mag_i) * FullW'(gain_i);
  assign shifted = full[FullW-1:GainFrac];
  assign ext     = signed'({{(ProdW-ShW){1'b0}}, shifted});
  assign prod_o  = (neg_i ^ inv_i) ? -ext : ext;

endmodule

/* src/pidff_update.sv */
// Integrator, drive and mode state, updated once per word, plus the result register.
module pidff_update
  import pidff_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  prod_t     prod_i,
  input  cfg_t      cfg_i,
  output out_word_t result_o
);

  localparam int unsigned SumW = 48;

  logic signed [SigW-1:0] integ_q, drive_q;
  logic                   was_auto_q;
  out_word_t              result_q;

  logic signed [SumW-1:0] lo, hi, half_lo, half_hi;
  logic signed [SumW-1:0] drive_ext, integ_ext;
  logic signed [SumW-1:0] p_ext, i_ext, d_ext, f_ext;
  logic signed [SumW-1:0] integ_base, integ_new, pid_c, base, final_drive;

  function automatic logic signed [SumW-1:0] clampv(
    input logic signed [SumW-1:0] x,
    input logic signed [SumW-1:0] lo_v,
    input logic signed [SumW-1:0] hi_v
  );
    logic signed [SumW-1:0] r;
    if (x < lo_v) begin
      r = lo_v;
    end else if (x > hi_v) begin
      r = hi_v;
    end else begin
      r = x;
    end
    return r;
  endfunction

  // widen everything to the working width
  assign lo        = {{(SumW-SigW){cfg_i.out_min[SigW-1]}}, cfg_i.out_min};
  assign hi        = {{(SumW-SigW){cfg_i.out_max[SigW-1]}}, cfg_i.out_max};
  assign half_lo   = lo >>> 1;
  assign half_hi   = hi >>> 1;
  assign drive_ext = {{(SumW-SigW){drive_q[SigW-1]}}, drive_q};
  assign integ_ext = {{(SumW-SigW){integ_q[SigW-1]}}, integ_q};
  assign p_ext = {{(SumW-ProdW){prod_i.p_term[ProdW-1]}}, prod_i.p_term};
  assign i_ext = {{(SumW-ProdW){prod_i.i_term[ProdW-1]}}, prod_i.i_term};
  assign d_ext = {{(SumW-ProdW){prod_i.d_term[ProdW-1]}}, prod_i.d_term};
  assign f_ext = {{(SumW-ProdW){prod_i.f_term[ProdW-1]}}, prod_i.f_term};

  // bumpless transfer: integrator starts from the held drive
  assign integ_base = was_auto_q ? integ_ext : clampv(drive_ext, lo, hi);
  assign integ_new  = clampv(integ_base + i_ext, half_lo, half_hi);
  assign pid_c      = clampv(p_ext + integ_new - d_ext, lo, hi);

  // manual mode holds the drive; feedforward acts in both modes
  assign base        = cfg_i.automatic_cfg ? pid_c : drive_ext;
  assign final_drive = prod_i.ff_enable ? clampv(base + f_ext, lo, hi) : base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      drive_q    <= '0;
      was_auto_q <= 1'b0;
    end else if (load_i) begin
      if (cfg_i.automatic_cfg) begin
        integ_q <= integ_new[SigW-1:0];
      end
      drive_q    <= final_drive[SigW-1:0];
      was_auto_q <= cfg_i.automatic_cfg;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q.drive    <= final_drive[SigW-1:0];
      result_q.computed <= cfg_i.automatic_cfg;
    end
  end

  assign result_o = result_q;

endmodule
